>>> hw/rtl/prp_pkg.sv
// ----------------------------------------------------------------------------
// prp_pkg
// Shared widths, register codes, sideband type and rounding helper for the
// pinhole radial projection pipeline.
// ----------------------------------------------------------------------------
package prp_pkg;

  localparam int unsigned QW  = 16;  // quaternion component, Q1.14
  localparam int unsigned PW  = 32;  // world coordinate, Q16.16
  localparam int unsigned OW  = 33;  // point minus camera
  localparam int unsigned RW  = 30;  // rotation entry, Q24
  localparam int unsigned MW  = 63;  // rotation entry times offset
  localparam int unsigned SW  = 66;  // wide working width for rounding
  localparam int unsigned CW  = 42;  // camera-frame coordinate, Q16
  localparam int unsigned NW  = 64;  // divider dividend
  localparam int unsigned QB  = 31;  // quotient bits
  localparam int unsigned NRW = 32;  // normalized coordinate, Q20
  localparam int unsigned NDW = 40;  // distorted coordinate, Q20
  localparam int unsigned PXW = 24;  // pixel, Q16.8
  localparam int unsigned FW  = 24;  // focal length / centre
  localparam int unsigned KW  = 21;  // radial coefficient
  localparam int unsigned IW  = 15;  // image size

  localparam logic signed [SW-1:0] Lim31 = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] Lim38 = SW'(64'sd274877906943);

  typedef enum logic [2:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTRE_X = 3'd2,
    REG_CENTRE_Y = 3'd3,
    REG_K1       = 3'd4,
    REG_K2       = 3'd5,
    REG_WIDTH    = 3'd6,
    REG_HEIGHT   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic op;        // 1: no bounds check
    logic in_front;
  } prp_tag_t;

  // add half an LSB, then floor shift right
  function automatic logic signed [SW-1:0] rnd_sh(input logic signed [SW-1:0] x,
                                                  input int unsigned s);
    rnd_sh = (x + (SW'(1) <<< (s - 1))) >>> s;
  endfunction

endpackage

>>> hw/rtl/prp_rotate.sv
// ----------------------------------------------------------------------------
// prp_rotate
// Builds the rotation matrix from the quaternion and rotates the offset
// point-minus-camera into the camera frame. Three register stages.
// ----------------------------------------------------------------------------
module prp_rotate (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic                              op_i,
  input  logic signed [prp_pkg::PW-1:0]     point_x_i,
  input  logic signed [prp_pkg::PW-1:0]     point_y_i,
  input  logic signed [prp_pkg::PW-1:0]     point_z_i,
  input  logic signed [prp_pkg::PW-1:0]     cam_x_i,
  input  logic signed [prp_pkg::PW-1:0]     cam_y_i,
  input  logic signed [prp_pkg::PW-1:0]     cam_z_i,
  input  logic signed [prp_pkg::QW-1:0]     quat_w_i,
  input  logic signed [prp_pkg::QW-1:0]     quat_i_i,
  input  logic signed [prp_pkg::QW-1:0]     quat_j_i,
  input  logic signed [prp_pkg::QW-1:0]     quat_k_i,
  output logic                              valid_o,
  output logic                              op_o,
  output logic signed [prp_pkg::CW-1:0]     cam_x_o,
  output logic signed [prp_pkg::CW-1:0]     cam_y_o,
  output logic signed [prp_pkg::CW-1:0]     depth_o
);
  import prp_pkg::*;

  function automatic logic signed [RW-1:0] rot_diag(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
    logic signed [39:0] s;
    s = (40'sd1 <<< 28) - ((40'(a) + 40'(b)) <<< 1);
    rot_diag = RW'(rnd_sh(SW'(s), 4));
  endfunction

  function automatic logic signed [RW-1:0] rot_off(input logic signed [39:0] t);
    rot_off = RW'(rnd_sh(SW'(t <<< 1), 4));
  endfunction

  logic signed [31:0] p_ii, p_jj, p_kk, p_ij, p_ik, p_jk, p_wi, p_wj, p_wk;
  logic signed [RW-1:0] rot_d [0:8];

  logic [2:0] v_q;
  logic [2:0] op_q;
  logic signed [RW-1:0] rot_q [0:8];
  logic signed [OW-1:0] off_q [0:2];
  logic signed [MW-1:0] mul_q [0:8];
  logic signed [CW-1:0] cc_q [0:2];

  assign p_ii = $signed(quat_i_i) * $signed(quat_i_i);
  assign p_jj = $signed(quat_j_i) * $signed(quat_j_i);
  assign p_kk = $signed(quat_k_i) * $signed(quat_k_i);
  assign p_ij = $signed(quat_i_i) * $signed(quat_j_i);
  assign p_ik = $signed(quat_i_i) * $signed(quat_k_i);
  assign p_jk = $signed(quat_j_i) * $signed(quat_k_i);
  assign p_wi = $signed(quat_w_i) * $signed(quat_i_i);
  assign p_wj = $signed(quat_w_i) * $signed(quat_j_i);
  assign p_wk = $signed(quat_w_i) * $signed(quat_k_i);

  // entries stored row-major: index row*3 + col
  always_comb begin
    rot_d[0] = rot_diag(p_jj, p_kk);
    rot_d[1] = rot_off(40'(p_ij) - 40'(p_wk));
    rot_d[2] = rot_off(40'(p_ik) + 40'(p_wj));
    rot_d[3] = rot_off(40'(p_ij) + 40'(p_wk));
    rot_d[4] = rot_diag(p_ii, p_kk);
    rot_d[5] = rot_off(40'(p_jk) - 40'(p_wi));
    rot_d[6] = rot_off(40'(p_ik) - 40'(p_wj));
    rot_d[7] = rot_off(40'(p_jk) + 40'(p_wi));
    rot_d[8] = rot_diag(p_ii, p_jj);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q     <= {op_q[1:0], op_i};
      rot_q    <= rot_d;
      off_q[0] <= OW'(point_x_i) - OW'(cam_x_i);
      off_q[1] <= OW'(point_y_i) - OW'(cam_y_i);
      off_q[2] <= OW'(point_z_i) - OW'(cam_z_i);
      // camera coordinate c uses column c of the matrix (transpose)
      for (int c = 0; c < 3; c++) begin
        for (int t = 0; t < 3; t++) begin
          mul_q[c*3+t] <= MW'(rot_q[t*3+c]) * MW'(off_q[t]);
        end
      end
      for (int c = 0; c < 3; c++) begin
        cc_q[c] <= CW'(rnd_sh(SW'(mul_q[c*3]) + SW'(mul_q[c*3+1]) + SW'(mul_q[c*3+2]), 24));
      end
    end
  end

  assign valid_o = v_q[2];
  assign op_o    = op_q[2];
  assign cam_x_o = cc_q[0];
  assign cam_y_o = cc_q[1];
  assign depth_o = -cc_q[2];

endmodule

>>> hw/rtl/prp_div.sv
// ----------------------------------------------------------------------------
// prp_div
// Two-lane pipelined restoring divider: n = round(num * 2^20 / depth),
// magnitude rounded half up and clamped to 31 bits. One quotient bit per stage.
// ----------------------------------------------------------------------------
module prp_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic                          op_i,
  input  logic signed [prp_pkg::CW-1:0] cam_x_i,
  input  logic signed [prp_pkg::CW-1:0] cam_y_i,
  input  logic signed [prp_pkg::CW-1:0] depth_i,
  output logic                          valid_o,
  output prp_pkg::prp_tag_t             tag_o,
  output logic signed [prp_pkg::NRW-1:0] norm_x_o,
  output logic signed [prp_pkg::NRW-1:0] norm_y_o
);
  import prp_pkg::*;

  localparam int unsigned DW = CW;

  // prep stage
  logic signed [CW:0]   num_c [0:1];
  logic                 neg_c [0:1];
  logic [CW-1:0]        mag_c [0:1];
  logic [NW-1:0]        dvd_c [0:1];
  logic                 ovf_c [0:1];
  logic [DW-1:0]        den_c;
  prp_tag_t             tag_c;

  // stage 0 is prep, 1..QB produce quotient bits MSB first
  logic [QB:0]          v_q;
  prp_tag_t             tag_q [0:QB];
  logic [DW-1:0]        den_q [0:QB];
  logic [NW-1:0]        dvd_q [0:QB][0:1];
  logic [DW-1:0]        rem_q [0:QB][0:1];
  logic [QB-1:0]        quo_q [0:QB][0:1];
  logic                 neg_q [0:QB][0:1];
  logic                 ovf_q [0:QB][0:1];

  logic [DW:0]          trial_c [1:QB][0:1];
  logic                 ge_c    [1:QB][0:1];

  logic                 v_out_q;
  prp_tag_t             tag_out_q;
  logic signed [NRW-1:0] n_out_q [0:1];
  logic signed [NRW-1:0] qv_c [0:1];

  always_comb begin
    den_c          = DW'(depth_i);
    tag_c.op       = op_i;
    tag_c.in_front = !depth_i[CW-1] && (depth_i != '0);
    num_c[0]       = (CW+1)'(cam_x_i);
    num_c[1]       = -((CW+1)'(cam_y_i));
    for (int l = 0; l < 2; l++) begin
      neg_c[l] = num_c[l][CW];
      mag_c[l] = neg_c[l] ? CW'(-num_c[l]) : CW'(num_c[l]);
      dvd_c[l] = NW'({mag_c[l], 20'b0}) + NW'(den_c >> 1);
      ovf_c[l] = (dvd_c[l] >> QB) >= NW'(den_c);
    end
  end

  always_comb begin
    for (int s = 1; s <= QB; s++) begin
      for (int l = 0; l < 2; l++) begin
        trial_c[s][l] = {rem_q[s-1][l], dvd_q[s-1][l][QB-s]};
        ge_c[s][l]    = trial_c[s][l] >= {1'b0, den_q[s-1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      v_out_q <= 1'b0;
    end else if (en_i) begin
      v_q     <= {v_q[QB-1:0], valid_i};
      v_out_q <= v_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag_c;
      den_q[0] <= den_c;
      for (int l = 0; l < 2; l++) begin
        dvd_q[0][l] <= dvd_c[l];
        rem_q[0][l] <= DW'(dvd_c[l] >> QB);
        quo_q[0][l] <= '0;
        neg_q[0][l] <= neg_c[l];
        ovf_q[0][l] <= ovf_c[l];
      end
      for (int s = 1; s <= QB; s++) begin
        tag_q[s] <= tag_q[s-1];
        den_q[s] <= den_q[s-1];
        for (int l = 0; l < 2; l++) begin
          dvd_q[s][l] <= dvd_q[s-1][l];
          neg_q[s][l] <= neg_q[s-1][l];
          ovf_q[s][l] <= ovf_q[s-1][l];
          quo_q[s][l] <= {quo_q[s-1][l][QB-2:0], ge_c[s][l]};
          rem_q[s][l] <= ge_c[s][l] ? DW'(trial_c[s][l] - {1'b0, den_q[s-1]})
                                    : DW'(trial_c[s][l]);
        end
      end
      tag_out_q <= tag_q[QB];
      for (int l = 0; l < 2; l++) begin
        n_out_q[l] <= neg_q[QB][l] ? -qv_c[l] : qv_c[l];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      qv_c[l] = ovf_q[QB][l] ? NRW'(Lim31) : $signed({1'b0, quo_q[QB][l]});
    end
  end

  assign valid_o  = v_out_q;
  assign tag_o    = tag_out_q;
  assign norm_x_o = n_out_q[0];
  assign norm_y_o = n_out_q[1];

endmodule

>>> hw/rtl/prp_distort.sv
// ----------------------------------------------------------------------------
// prp_distort
// Radial distortion: r2 = |n|^2, factor = 1 + r2*(k1 + r2*k2), n' = n*factor.
// Eight register stages; the multiplies sit in alternate stages.
// ----------------------------------------------------------------------------
module prp_distort (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  prp_pkg::prp_tag_t              tag_i,
  input  logic signed [prp_pkg::NRW-1:0] norm_x_i,
  input  logic signed [prp_pkg::NRW-1:0] norm_y_i,
  input  logic signed [prp_pkg::KW-1:0]  radial_k1_i,
  input  logic signed [prp_pkg::KW-1:0]  radial_k2_i,
  output logic                           valid_o,
  output prp_pkg::prp_tag_t              tag_o,
  output logic signed [prp_pkg::NDW-1:0] dist_x_o,
  output logic signed [prp_pkg::NDW-1:0] dist_y_o
);
  import prp_pkg::*;

  function automatic logic signed [SW-1:0] sat_sym(input logic signed [SW-1:0] x,
                                                   input logic signed [SW-1:0] lim);
    if (x > lim) begin
      sat_sym = lim;
    end else if (x < -lim) begin
      sat_sym = -lim;
    end else begin
      sat_sym = x;
    end
  endfunction

  logic [7:0]             v_q;
  prp_tag_t               tag_q [1:8];
  logic signed [NRW-1:0]  nx_q [1:6];
  logic signed [NRW-1:0]  ny_q [1:6];

  logic [NRW-2:0]         ax_c, ay_c;
  logic [2*NRW-3:0]       sqx_q, sqy_q;
  logic [NW-1:0]          sq_sum_c;
  logic [NW-1:0]          sq_sh_c;
  logic [NRW-2:0]         r2_q [2:4];
  logic signed [52:0]     pk2_q;
  logic signed [NRW-1:0]  inner_q;
  logic signed [63:0]     pin_q;
  logic signed [NRW-1:0]  fac_q;
  logic signed [63:0]     pfx_q, pfy_q;
  logic signed [NDW-1:0]  ndx_q, ndy_q;

  // inputs are already clamped to +-(2^31-1), so magnitudes fit 31 bits
  assign ax_c     = norm_x_i[NRW-1] ? (NRW-1)'(-norm_x_i) : norm_x_i[NRW-2:0];
  assign ay_c     = norm_y_i[NRW-1] ? (NRW-1)'(-norm_y_i) : norm_y_i[NRW-2:0];
  assign sq_sum_c = NW'(sqx_q) + NW'(sqy_q) + (NW'(1) << 19);
  assign sq_sh_c  = sq_sum_c >> 20;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[6:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[1] <= tag_i;
      for (int s = 2; s <= 8; s++) begin
        tag_q[s] <= tag_q[s-1];
      end
      nx_q[1] <= norm_x_i;
      ny_q[1] <= norm_y_i;
      for (int s = 2; s <= 6; s++) begin
        nx_q[s] <= nx_q[s-1];
        ny_q[s] <= ny_q[s-1];
      end
      sqx_q   <= (2*NRW-2)'(ax_c) * (2*NRW-2)'(ax_c);
      sqy_q   <= (2*NRW-2)'(ay_c) * (2*NRW-2)'(ay_c);
      r2_q[2] <= (sq_sh_c > NW'(Lim31)) ? (NRW-1)'(Lim31) : sq_sh_c[NRW-2:0];
      r2_q[3] <= r2_q[2];
      r2_q[4] <= r2_q[3];
      pk2_q   <= 53'($signed({1'b0, r2_q[2]})) * 53'(radial_k2_i);
      inner_q <= NRW'(sat_sym(SW'(radial_k1_i) + rnd_sh(SW'(pk2_q), 20), Lim31));
      pin_q   <= 64'($signed({1'b0, r2_q[4]})) * 64'(inner_q);
      fac_q   <= NRW'(sat_sym((SW'(1) <<< 20) + rnd_sh(SW'(pin_q), 16), Lim31));
      pfx_q   <= 64'(nx_q[6]) * 64'(fac_q);
      pfy_q   <= 64'(ny_q[6]) * 64'(fac_q);
      ndx_q   <= NDW'(sat_sym(rnd_sh(SW'(pfx_q), 20), Lim38));
      ndy_q   <= NDW'(sat_sym(rnd_sh(SW'(pfy_q), 20), Lim38));
    end
  end

  assign valid_o  = v_q[7];
  assign tag_o    = tag_q[8];
  assign dist_x_o = ndx_q;
  assign dist_y_o = ndy_q;

endmodule

>>> hw/rtl/prp_map.sv
// ----------------------------------------------------------------------------
// prp_map
// Pixel mapping: centre + focal * n', saturated to Q16.8, then the image
// bounds check. The 24x40 product is split into two 24x20 partial products.
// The last stage is the output register.
// ----------------------------------------------------------------------------
module prp_map (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  prp_pkg::prp_tag_t              tag_i,
  input  logic signed [prp_pkg::NDW-1:0] dist_x_i,
  input  logic signed [prp_pkg::NDW-1:0] dist_y_i,
  input  logic [prp_pkg::FW-1:0]         focal_x_i,
  input  logic [prp_pkg::FW-1:0]         focal_y_i,
  input  logic signed [prp_pkg::FW-1:0]  centre_x_i,
  input  logic signed [prp_pkg::FW-1:0]  centre_y_i,
  input  logic [prp_pkg::IW-1:0]         image_width_i,
  input  logic [prp_pkg::IW-1:0]         image_height_i,
  output logic                           valid_o,
  output logic                           in_front_o,
  output logic                           visible_o,
  output logic signed [prp_pkg::PXW-1:0] pixel_x_o,
  output logic signed [prp_pkg::PXW-1:0] pixel_y_o
);
  import prp_pkg::*;

  localparam int unsigned HW = NDW / 2;   // low half of n'

  localparam logic signed [SW-1:0] PixMax = SW'(64'sd8388607);
  localparam logic signed [SW-1:0] PixMin = SW'(-64'sd8388608);

  function automatic logic signed [PXW-1:0] sat_pix(input logic signed [SW-1:0] x);
    if (x > PixMax) begin
      sat_pix = PXW'(PixMax);
    end else if (x < PixMin) begin
      sat_pix = PXW'(PixMin);
    end else begin
      sat_pix = PXW'(x);
    end
  endfunction

  function automatic logic in_range(input logic signed [PXW-1:0] p,
                                    input logic [IW-1:0] lim);
    in_range = !p[PXW-1] && ({1'b0, p[PXW-2:0]} < PXW'({lim, 8'b0}));
  endfunction

  logic [3:0]              v_q;
  prp_tag_t                tag_q [1:3];
  logic signed [FW+HW:0]   hix_q, hiy_q;
  logic [FW+HW-1:0]        lox_q, loy_q;
  logic signed [SW-1:0]    sumx_q, sumy_q;
  logic signed [PXW-1:0]   px_q, py_q;
  logic                    inf_q, vis_q;
  logic signed [PXW-1:0]   pxo_q, pyo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[1] <= tag_i;
      tag_q[2] <= tag_q[1];
      tag_q[3] <= tag_q[2];
      hix_q  <= (FW+HW+1)'($signed({1'b0, focal_x_i})) * (FW+HW+1)'($signed(dist_x_i[NDW-1:HW]));
      hiy_q  <= (FW+HW+1)'($signed({1'b0, focal_y_i})) * (FW+HW+1)'($signed(dist_y_i[NDW-1:HW]));
      lox_q  <= (FW+HW)'(focal_x_i) * (FW+HW)'(dist_x_i[HW-1:0]);
      loy_q  <= (FW+HW)'(focal_y_i) * (FW+HW)'(dist_y_i[HW-1:0]);
      sumx_q <= (SW'(hix_q) <<< HW) + SW'($signed({1'b0, lox_q}));
      sumy_q <= (SW'(hiy_q) <<< HW) + SW'($signed({1'b0, loy_q}));
      px_q   <= sat_pix(SW'(centre_x_i) + rnd_sh(sumx_q, 20));
      py_q   <= sat_pix(SW'(centre_y_i) + rnd_sh(sumy_q, 20));
      // behind the camera everything reads zero
      inf_q  <= tag_q[3].in_front;
      vis_q  <= tag_q[3].in_front &&
                (tag_q[3].op || (in_range(px_q, image_width_i) &&
                                 in_range(py_q, image_height_i)));
      pxo_q  <= tag_q[3].in_front ? px_q : '0;
      pyo_q  <= tag_q[3].in_front ? py_q : '0;
    end
  end

  assign valid_o    = v_q[3];
  assign in_front_o = inf_q;
  assign visible_o  = vis_q;
  assign pixel_x_o  = pxo_q;
  assign pixel_y_o  = pyo_q;

endmodule

>>> hw/rtl/pinhole_radial_projection.sv
// ----------------------------------------------------------------------------
// pinhole_radial_projection
// Projects world points through a rotated pinhole camera with k1/k2 radial
// distortion to saturated Q16.8 pixel coordinates.
//
// Usage:
//   s_axis carries one point per transfer: tdata holds point, camera position
//   and quaternion; tuser selects bounded (0) or unbounded (1) mode.
//   m_axis returns one result per point: tdata holds pixel_x and pixel_y,
//   tuser holds the in-front and visible flags.
//   Camera and image registers are written through cfg_we_i/cfg_idx_i/
//   cfg_data_i only while the pipeline is empty; the user must ensure this.
//   Throughput is one point per cycle while the receiver does not hold tready
//   low. The pipeline depth is set by the divider, one quotient bit per stage,
//   plus rotation, distortion and mapping stages.
//   The whole pipeline advances together; when the receiver holds tready low
//   with a result waiting, every stage holds and s_axis_tready drops, so no
//   item is lost or repeated.
//   Reset empties the pipeline and restores the default camera registers.
// ----------------------------------------------------------------------------
module pinhole_radial_projection (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // point_x, point_y, point_z, cam_x, cam_y, cam_z, quat_w, quat_i, quat_j, quat_k
  input  logic [255:0] s_axis_tdata,
  // op
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pixel_x, pixel_y
  output logic [47:0]  m_axis_tdata,
  // in_front, visible
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [prp_pkg::FW-1:0] cfg_data_i
);
  import prp_pkg::*;

  logic [FW-1:0]        focal_x_q, focal_y_q;
  logic signed [FW-1:0] centre_x_q, centre_y_q;
  logic signed [KW-1:0] k1_q, k2_q;
  logic [IW-1:0]        width_q, height_q;

  logic                 adv;
  logic                 rot_v, rot_op;
  logic signed [CW-1:0] rot_cx, rot_cy, rot_depth;
  logic                 div_v;
  prp_tag_t             div_tag;
  logic signed [NRW-1:0] div_nx, div_ny;
  logic                 dis_v;
  prp_tag_t             dis_tag;
  logic signed [NDW-1:0] dis_x, dis_y;
  logic                 out_in_front, out_visible;
  logic signed [PXW-1:0] out_px, out_py;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= FW'(128000);
      focal_y_q  <= FW'(128000);
      centre_x_q <= FW'(81920);
      centre_y_q <= FW'(61440);
      k1_q       <= '0;
      k2_q       <= '0;
      width_q    <= IW'(640);
      height_q   <= IW'(480);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_FOCAL_X:  focal_x_q  <= cfg_data_i;
        REG_FOCAL_Y:  focal_y_q  <= cfg_data_i;
        REG_CENTRE_X: centre_x_q <= cfg_data_i;
        REG_CENTRE_Y: centre_y_q <= cfg_data_i;
        REG_K1:       k1_q       <= cfg_data_i[KW-1:0];
        REG_K2:       k2_q       <= cfg_data_i[KW-1:0];
        REG_WIDTH:    width_q    <= cfg_data_i[IW-1:0];
        REG_HEIGHT:   height_q   <= cfg_data_i[IW-1:0];
      endcase
    end
  end

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  prp_rotate u_rotate (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .valid_i   (s_axis_tvalid),
    .op_i      (s_axis_tuser),
    .point_x_i (s_axis_tdata[31:0]),
    .point_y_i (s_axis_tdata[63:32]),
    .point_z_i (s_axis_tdata[95:64]),
    .cam_x_i   (s_axis_tdata[127:96]),
    .cam_y_i   (s_axis_tdata[159:128]),
    .cam_z_i   (s_axis_tdata[191:160]),
    .quat_w_i  (s_axis_tdata[207:192]),
    .quat_i_i  (s_axis_tdata[223:208]),
    .quat_j_i  (s_axis_tdata[239:224]),
    .quat_k_i  (s_axis_tdata[255:240]),
    .valid_o   (rot_v),
    .op_o      (rot_op),
    .cam_x_o   (rot_cx),
    .cam_y_o   (rot_cy),
    .depth_o   (rot_depth)
  );

  prp_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (rot_v),
    .op_i     (rot_op),
    .cam_x_i  (rot_cx),
    .cam_y_i  (rot_cy),
    .depth_i  (rot_depth),
    .valid_o  (div_v),
    .tag_o    (div_tag),
    .norm_x_o (div_nx),
    .norm_y_o (div_ny)
  );

  prp_distort u_distort (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .valid_i     (div_v),
    .tag_i       (div_tag),
    .norm_x_i    (div_nx),
    .norm_y_i    (div_ny),
    .radial_k1_i (k1_q),
    .radial_k2_i (k2_q),
    .valid_o     (dis_v),
    .tag_o       (dis_tag),
    .dist_x_o    (dis_x),
    .dist_y_o    (dis_y)
  );

  prp_map u_map (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (adv),
    .valid_i        (dis_v),
    .tag_i          (dis_tag),
    .dist_x_i       (dis_x),
    .dist_y_i       (dis_y),
    .focal_x_i      (focal_x_q),
    .focal_y_i      (focal_y_q),
    .centre_x_i     (centre_x_q),
    .centre_y_i     (centre_y_q),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .valid_o        (m_axis_tvalid),
    .in_front_o     (out_in_front),
    .visible_o      (out_visible),
    .pixel_x_o      (out_px),
    .pixel_y_o      (out_py)
  );

  assign m_axis_tdata = {out_py, out_px};
  assign m_axis_tuser = {out_visible, out_in_front};

  // a point behind the camera reports nothing else
  a_behind_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
    else $error("behind-camera result not cleared");

  a_vis_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("visible without in_front");

  // input only backs up behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with no output backpressure");

endmodule
